// ===== rtl/ssfr_pkg.sv =====
// Shared types and constants for the stuffed serial frame receiver.
`timescale 1ns / 1ps

package ssfr_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [8:0] t_len;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CSUM_ERR = 2'd2,
        ST_DROP     = 2'd3
    } t_status;

    localparam t_byte C_HDR_BYTE   = 8'hFF;
    localparam t_byte C_STUFF_BYTE = 8'h55;

    localparam int C_HDR_OVERHEAD = 4;
    localparam int C_MIN_TOTAL    = 5;
    localparam int C_MAX_FRAME    = 256;
    localparam int C_BYTE_SPAN    = 256;

    localparam t_len C_CFG_RESET  = 9'd256;
    localparam t_len C_IDX_START  = 9'd2;
    localparam t_len C_IDX_LEN_HI = 9'd2;
    localparam t_len C_IDX_LEN_LO = 9'd3;

    typedef struct packed {
        logic    byte_valid;
        t_byte   frame_byte;
        t_byte   byte_index;
        logic    frame_restart;
        logic    frame_end;
        t_status frame_status;
        t_len    frame_length;
    } t_result;

endpackage

// ===== rtl/ssfr_rx_if.sv =====
// Valid/ready channel carrying one received byte.
`timescale 1ns / 1ps

interface ssfr_rx_if;
    import ssfr_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ssfr_res_if.sv =====
// Valid/ready channel carrying one deframer result.
`timescale 1ns / 1ps

interface ssfr_res_if;
    import ssfr_pkg::*;

    logic       valid;
    logic       ready;
    logic       byte_valid;
    t_byte      frame_byte;
    t_byte      byte_index;
    logic       frame_restart;
    logic       frame_end;
    logic [1:0] frame_status;
    t_len       frame_length;

    modport source(
        output valid, output byte_valid, output frame_byte, output byte_index,
        output frame_restart, output frame_end, output frame_status,
        output frame_length, input ready
    );
    modport sink(
        input valid, input byte_valid, input frame_byte, input byte_index,
        input frame_restart, input frame_end, input frame_status,
        input frame_length, output ready
    );
endinterface

// ===== rtl/ssfr_in_reg.sv =====
// Input register stage holding one received byte.
`timescale 1ns / 1ps

module ssfr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ssfr_rx_if.sink        i_rx,
    input  logic           i_advance,
    output logic           o_valid,
    output ssfr_pkg::t_byte o_byte
);
    import ssfr_pkg::*;

    logic  r_valid;
    t_byte r_byte;

    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== rtl/ssfr_deframe.sv =====
// Frame state and per-byte header, stuffing, length and checksum logic.
`timescale 1ns / 1ps

module ssfr_deframe #(
    parameter int MAX_FRAME = ssfr_pkg::C_MAX_FRAME
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ssfr_pkg::t_byte   i_byte,
    input  ssfr_pkg::t_len    i_max_frame_bytes,
    output ssfr_pkg::t_result o_result
);
    import ssfr_pkg::*;

    localparam int   LimitCapInt = (MAX_FRAME < C_BYTE_SPAN) ? MAX_FRAME : C_BYTE_SPAN;
    localparam t_len LIMIT_CAP   = t_len'(LimitCapInt);

    logic  r_in_frame, n_in_frame;
    t_byte r_prev_byte, n_prev_byte;
    t_len  r_held_count, n_held_count;
    t_byte r_length_high, n_length_high;
    t_len  r_expected_total, n_expected_total;
    t_byte r_running_sum, n_running_sum;

    t_len        w_limit;
    logic        w_header;
    logic        w_stuff;
    logic        w_ended;
    logic [16:0] w_total;
    t_result     w_res;

    assign w_limit  = (i_max_frame_bytes > LIMIT_CAP) ? LIMIT_CAP : i_max_frame_bytes;
    assign w_header = (r_prev_byte == C_HDR_BYTE) && (i_byte == C_HDR_BYTE);
    assign w_stuff  = (r_prev_byte == C_HDR_BYTE) && (i_byte == C_STUFF_BYTE);
    assign w_total  = {1'b0, r_length_high, i_byte} + 17'(C_HDR_OVERHEAD);

    always_comb begin
        n_in_frame        = r_in_frame;
        n_prev_byte       = r_prev_byte;
        n_held_count      = r_held_count;
        n_length_high     = r_length_high;
        n_expected_total  = r_expected_total;
        n_running_sum     = r_running_sum;
        w_ended           = 1'b0;
        w_res             = '0;
        w_res.frame_status = ST_NONE;

        if (w_header) begin
            if (!r_in_frame || (r_held_count > t_len'(C_HDR_OVERHEAD))) begin
                n_in_frame          = 1'b1;
                n_held_count        = C_IDX_START;
                n_length_high       = '0;
                n_expected_total    = '0;
                n_running_sum       = '0;
                w_res.frame_restart = r_in_frame;
            end
        end else if (w_stuff) begin
            // drop stuffing byte
        end else if (r_in_frame) begin
            n_held_count      = r_held_count + 9'd1;
            w_res.byte_valid  = 1'b1;
            w_res.frame_byte  = i_byte;
            w_res.byte_index  = r_held_count[7:0];
            n_running_sum     = r_running_sum + i_byte;
            if (r_held_count == C_IDX_LEN_HI) begin
                n_length_high = i_byte;
            end else if (r_held_count == C_IDX_LEN_LO) begin
                n_expected_total = w_total[8:0];
                if ((w_total > {8'd0, w_limit}) || (w_total < 17'(C_MIN_TOTAL))) begin
                    w_res.frame_restart = 1'b1;
                    w_res.frame_end     = 1'b1;
                    w_res.frame_status  = ST_DROP;
                    w_ended             = 1'b1;
                end
            end else if ((n_held_count > t_len'(C_HDR_OVERHEAD))
                         && (n_held_count == r_expected_total)) begin
                w_res.frame_end    = 1'b1;
                w_res.frame_status = (i_byte == r_running_sum) ? ST_GOOD : ST_CSUM_ERR;
                w_res.frame_length = r_expected_total;
                w_ended            = 1'b1;
            end
        end

        if (w_ended) begin
            n_in_frame   = 1'b0;
            n_held_count = '0;
            n_prev_byte  = '0;
        end else begin
            n_prev_byte  = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame        <= 1'b0;
            r_prev_byte       <= '0;
            r_held_count      <= '0;
            r_length_high     <= '0;
            r_expected_total  <= '0;
            r_running_sum     <= '0;
        end else if (i_step) begin
            r_in_frame        <= n_in_frame;
            r_prev_byte       <= n_prev_byte;
            r_held_count      <= n_held_count;
            r_length_high     <= n_length_high;
            r_expected_total  <= n_expected_total;
            r_running_sum     <= n_running_sum;
        end
    end

    assign o_result = w_res;
endmodule

// ===== rtl/ssfr_out_reg.sv =====
// Result register stage driving the result channel.
`timescale 1ns / 1ps

module ssfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ssfr_pkg::t_result i_result,
    ssfr_res_if.source        o_res,
    output logic              o_stall
);
    import ssfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_stall = r_valid && !o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.byte_valid    = r_result.byte_valid;
    assign o_res.frame_byte    = r_result.frame_byte;
    assign o_res.byte_index    = r_result.byte_index;
    assign o_res.frame_restart = r_result.frame_restart;
    assign o_res.frame_end     = r_result.frame_end;
    assign o_res.frame_status  = r_result.frame_status;
    assign o_res.frame_length  = r_result.frame_length;
endmodule

// ===== rtl/stuffed_serial_frame_receiver_core.sv =====
// Stuffed serial frame receiver: takes raw bytes, yields destuffed frame bytes and status.
// Usage:
//   i_rx carries one raw link byte per transfer; o_res returns exactly one result per
//   accepted byte, in order: the destuffed frame byte with its index (or none), restart
//   and end flags, checksum or length-range drop status and the frame total on completion.
//   i_cfg_wr_en / i_cfg_wr_data write the maximum frame size; write it only while idle.
// Path: a transferred byte is captured in an input register, then takes one pass of
//   header, stuffing, length and checksum logic into the result register.
// Throughput: one byte per cycle while o_res.ready is high; the frame state registers
//   update with each advancing byte.
// Reset: i_rst_n low at a clock edge empties both stages, returns to hunting for a
//   header and sets the maximum frame size to 256.
// Stall: while o_res.ready is low the result is held; one more byte is taken into the
//   input register, then i_rx.ready drops until the result transfers.
`timescale 1ns / 1ps

module stuffed_serial_frame_receiver_core #(
    parameter int MAX_FRAME = ssfr_pkg::C_MAX_FRAME
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  ssfr_pkg::t_len i_cfg_wr_data,
    ssfr_rx_if.sink        i_rx,
    ssfr_res_if.source     o_res
);
    import ssfr_pkg::*;

    t_len    r_max_frame_bytes;
    logic    w_s1_valid;
    t_byte   w_s1_byte;
    logic    w_out_stall;
    logic    w_advance;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= C_CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_frame_bytes <= i_cfg_wr_data;
        end
    end

    assign w_advance = w_s1_valid && !w_out_stall;

    ssfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_byte    (w_s1_byte)
    );

    ssfr_deframe #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_advance),
        .i_byte            (w_s1_byte),
        .i_max_frame_bytes (r_max_frame_bytes),
        .o_result          (w_result)
    );

    ssfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .o_res    (o_res),
        .o_stall  (w_out_stall)
    );

`ifndef ASSERT_OFF
    a_checked_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && ((o_res.frame_status == ST_GOOD) || (o_res.frame_status == ST_CSUM_ERR))
        |-> o_res.frame_end && o_res.byte_valid && (o_res.frame_length >= t_len'(C_MIN_TOTAL))
            && (o_res.frame_length <= t_len'(C_BYTE_SPAN)))
        else $error("checked frame end with bad flags or length");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.frame_status == ST_DROP)
        |-> o_res.frame_restart && o_res.frame_end && o_res.byte_valid
            && (o_res.byte_index == 8'd3) && (o_res.frame_length == '0))
        else $error("dropped frame with bad flags");

    a_end_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_end |-> o_res.byte_valid
            && (o_res.frame_status != ST_NONE))
        else $error("frame end without byte or status");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_advance))
        else $error("result appeared without an advancing byte");
`endif

endmodule

// ===== tb/tb_stuffed_serial_frame_receiver_core.sv =====
// Self-checking regression for the stuffed serial frame receiver core.
`timescale 1ns / 1ps

module tb_stuffed_serial_frame_receiver_core;
    import ssfr_pkg::*;

    localparam int MAX_GAP    = 8;
    localparam int RUN_LIMIT  = 400000;
    localparam int SETTLE     = 12;

    typedef enum logic [1:0] {
        LINK_BYTE,
        WRITE_LIMIT,
        DRAIN
    } t_link_op;

    typedef struct {
        t_link_op op;
        t_len     value;
    } t_link_item;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    t_len cfg_wr_data;

    ssfr_rx_if  rx_ch ();
    ssfr_res_if res_ch ();

    stuffed_serial_frame_receiver_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_ch),
        .o_res         (res_ch)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    t_link_item  tx_plan[$];
    t_result     expected_results[$];
    int unsigned mismatch_count = 0;

    t_len        frame_limit_reg = C_CFG_RESET;
    logic        rx_in_frame     = 1'b0;
    t_byte       rx_prev         = '0;
    logic [8:0]  held_cnt        = '0;
    t_byte       len_hi          = '0;
    logic [16:0] want_total      = '0;
    t_byte       sum_run         = '0;
    t_byte       sum_prior       = '0;

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        mismatch_count++;
        $display("%0t ns  mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic void open_frame();
        rx_in_frame = 1'b1;
        held_cnt    = 9'd2;
        len_hi      = '0;
        want_total  = '0;
        sum_run     = '0;
        sum_prior   = '0;
    endfunction

    function automatic t_result deframe_byte(input t_byte b);
        t_result     r;
        logic        ended;
        logic [8:0]  idx;
        logic [16:0] limit;
        r     = '0;
        ended = 1'b0;
        limit = 17'(frame_limit_reg);
        if (limit > 17'(C_MAX_FRAME)) limit = 17'(C_MAX_FRAME);
        if (limit > 17'(C_BYTE_SPAN)) limit = 17'(C_BYTE_SPAN);

        if (rx_prev == C_HDR_BYTE && b == C_HDR_BYTE) begin
            if (!rx_in_frame) begin
                open_frame();
            end else if (held_cnt > 9'(C_HDR_OVERHEAD)) begin
                open_frame();
                r.frame_restart = 1'b1;
            end
        end else if (rx_prev == C_HDR_BYTE && b == C_STUFF_BYTE) begin
            // drop stuffing byte
        end else if (rx_in_frame) begin
            idx          = held_cnt;
            held_cnt     = held_cnt + 9'd1;
            r.byte_valid = 1'b1;
            r.frame_byte = b;
            r.byte_index = idx[7:0];
            sum_prior    = sum_run;
            sum_run      = sum_run + b;
            if (idx == C_IDX_LEN_HI) begin
                len_hi = b;
            end else if (idx == C_IDX_LEN_LO) begin
                want_total = 17'({len_hi, b}) + 17'(C_HDR_OVERHEAD);
                if (want_total > limit || want_total < 17'(C_MIN_TOTAL)) begin
                    r.frame_restart = 1'b1;
                    r.frame_end     = 1'b1;
                    r.frame_status  = ST_DROP;
                    ended           = 1'b1;
                end
            end else if (held_cnt > 9'(C_HDR_OVERHEAD) && 17'(held_cnt) == want_total) begin
                r.frame_end    = 1'b1;
                r.frame_status = (b == sum_prior) ? ST_GOOD : ST_CSUM_ERR;
                r.frame_length = want_total[8:0];
                ended          = 1'b1;
            end
        end

        if (ended) begin
            rx_in_frame = 1'b0;
            held_cnt    = '0;
            rx_prev     = '0;
        end else begin
            rx_prev = b;
        end
        return r;
    endfunction

    // Driver: present link bytes, register writes and drain points in plan order.
    int unsigned gap_left  = 0;
    logic        src_quiet = 1'b0;

    always @(posedge clk) begin : drive_link
        logic  next_valid;
        t_byte next_byte;
        logic  next_wr_en;
        t_len  next_wr_data;
        if (!rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            cfg_wr_en     <= 1'b0;
            cfg_wr_data   <= '0;
            gap_left      = 0;
        end else begin
            next_valid   = rx_ch.valid;
            next_byte    = rx_ch.rx_byte;
            next_wr_en   = 1'b0;
            next_wr_data = cfg_wr_data;
            if (rx_ch.valid && rx_ch.ready) begin
                expected_results.push_back(deframe_byte(rx_ch.rx_byte));
                next_valid = 1'b0;
                gap_left   = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 63) == 0) src_quiet = !src_quiet;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tx_plan.size() != 0) begin
                    case (tx_plan[0].op)
                        LINK_BYTE: begin
                            next_valid = 1'b1;
                            next_byte  = tx_plan[0].value[7:0];
                            void'(tx_plan.pop_front());
                        end
                        WRITE_LIMIT: begin
                            if (expected_results.size() == 0) begin
                                next_wr_en      = 1'b1;
                                next_wr_data    = tx_plan[0].value;
                                frame_limit_reg = tx_plan[0].value;
                                void'(tx_plan.pop_front());
                            end
                        end
                        DRAIN: begin
                            if (expected_results.size() == 0) void'(tx_plan.pop_front());
                        end
                        default: void'(tx_plan.pop_front());
                    endcase
                end
            end
            rx_ch.valid   <= next_valid;
            rx_ch.rx_byte <= next_byte;
            cfg_wr_en     <= next_wr_en;
            cfg_wr_data   <= next_wr_data;
        end
    end

    // Monitor: check each result transfer against the oldest expectation.
    int unsigned stall_left = 0;
    logic        snk_quiet  = 1'b0;

    always @(posedge clk) begin : watch_results
        t_result want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 17'(res_ch.frame_byte), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", 17'(res_ch.byte_valid), 17'(want.byte_valid));
                    if (res_ch.frame_byte !== want.frame_byte)
                        report_mismatch("frame_byte", 17'(res_ch.frame_byte), 17'(want.frame_byte));
                    if (res_ch.byte_index !== want.byte_index)
                        report_mismatch("byte_index", 17'(res_ch.byte_index), 17'(want.byte_index));
                    if (res_ch.frame_restart !== want.frame_restart)
                        report_mismatch("frame_restart", 17'(res_ch.frame_restart),
                                        17'(want.frame_restart));
                    if (res_ch.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 17'(res_ch.frame_end), 17'(want.frame_end));
                    if (res_ch.frame_status !== want.frame_status)
                        report_mismatch("frame_status", 17'(res_ch.frame_status),
                                        17'(want.frame_status));
                    if (res_ch.frame_length !== want.frame_length)
                        report_mismatch("frame_length", 17'(res_ch.frame_length),
                                        17'(want.frame_length));
                end
                stall_left = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 63) == 0) snk_quiet = !snk_quiet;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_ch.ready <= (stall_left == 0);
        end
    end

    task automatic push_op(input t_link_op op, input t_len value);
        t_link_item it;
        it.op    = op;
        it.value = value;
        tx_plan.push_back(it);
    endtask

    function automatic t_byte pick_payload();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2) return C_HDR_BYTE;
        if (r == 2) return C_STUFF_BYTE;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Append header, length, payload and checksum; stuff every 0xFF after the header.
    // A nonzero keep cuts the frame after that many bytes past the header.
    task automatic push_frame(input int unsigned body, input bit bad_sum, input int unsigned keep);
        t_byte       frame_bytes[$];
        t_byte       csum;
        int unsigned n;
        frame_bytes.push_back(t_byte'(body >> 8));
        frame_bytes.push_back(t_byte'(body));
        for (n = 1; n < body && (keep == 0 || n < keep); n++)
            frame_bytes.push_back(pick_payload());
        csum = '0;
        foreach (frame_bytes[i]) csum = csum + frame_bytes[i];
        if (bad_sum) csum = csum ^ t_byte'($urandom_range(1, 255));
        frame_bytes.push_back(csum);
        push_op(LINK_BYTE, 9'(C_HDR_BYTE));
        push_op(LINK_BYTE, 9'(C_HDR_BYTE));
        foreach (frame_bytes[i]) begin
            if (keep != 0 && i >= keep) break;
            push_op(LINK_BYTE, 9'(frame_bytes[i]));
            if (frame_bytes[i] == C_HDR_BYTE) push_op(LINK_BYTE, 9'(C_STUFF_BYTE));
        end
    endtask

    task automatic push_random_traffic(input int unsigned count, input int eff_limit);
        int unsigned start;
        int unsigned pick;
        int unsigned sel;
        int          body;
        int unsigned n;
        start = tx_plan.size();
        while (tx_plan.size() - start < count) begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 19);
            if (sel == 0) body = $urandom_range(1, 252);
            else if (sel == 1) body = eff_limit - C_HDR_OVERHEAD;
            else if (sel == 2) body = eff_limit - C_HDR_OVERHEAD + 1;
            else body = $urandom_range(1, 20);
            if (body < 1) body = 1;
            if (pick < 72) begin
                push_frame(body, $urandom_range(0, 5) == 0, 0);
            end else if (pick < 82) begin
                push_frame(body, 1'b0, $urandom_range(1, body + 1));
            end else if (pick < 90) begin
                push_frame($urandom_range(0, 1) ? $urandom_range(253, 65535) : 0, 1'b0,
                           $urandom_range(2, 5));
            end else begin
                for (n = $urandom_range(1, 6); n > 0; n--) begin
                    case ($urandom_range(0, 3))
                        0: push_op(LINK_BYTE, 9'(C_HDR_BYTE));
                        1: push_op(LINK_BYTE, 9'(C_STUFF_BYTE));
                        default: push_op(LINK_BYTE, 9'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
        while (tx_plan.size() - start > count) void'(tx_plan.pop_back());
    endtask

    initial begin : run_ctl
        t_byte       opening[26];
        t_len        phase_limit[7];
        int unsigned phase_items[7];
        int          eff;
        int unsigned run_cycles;
        logic        drained;

        opening = '{
            8'hFF, 8'hFF, 8'h00, 8'h01, 8'h01,
            8'hFF, 8'hFF, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'h00, 8'h0A, 8'h11, 8'hFF, 8'hFF,
            8'h01, 8'h00,
            8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h55, 8'hAA
        };
        phase_limit = '{9'd5, 9'd511, 9'd4, 9'd0, 9'd0, 9'd256, 9'd300};
        phase_items = '{50, 120, 30, 20, 130, 75, 100};

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;

        foreach (opening[i]) push_op(LINK_BYTE, 9'(opening[i]));
        phase_limit[4] = t_len'($urandom_range(6, 255));
        foreach (phase_limit[p]) begin
            push_op(WRITE_LIMIT, phase_limit[p]);
            eff = (phase_limit[p] > 9'(C_MAX_FRAME)) ? C_MAX_FRAME : int'(phase_limit[p]);
            push_random_traffic(phase_items[p], eff);
            if (p == 5) begin
                push_op(DRAIN, '0);
                push_random_traffic(phase_items[p], eff);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_cycles = 0;
        drained    = 1'b0;
        while (!drained && run_cycles < RUN_LIMIT) begin
            @(negedge clk);
            run_cycles++;
            drained = tx_plan.size() == 0 && !rx_ch.valid && expected_results.size() == 0;
        end

        if (!drained) begin
            $display("stuffed_serial_frame_receiver_core regression: fail");
        end else begin
            repeat (SETTLE) @(negedge clk);
            if (expected_results.size() != 0)
                report_mismatch("results never returned", 17'(expected_results.size()), '0);
            if (mismatch_count == 0)
                $display("stuffed_serial_frame_receiver_core regression: pass");
            else
                $display("stuffed_serial_frame_receiver_core regression: fail");
        end
        $finish;
    end

endmodule
